FILE: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the cycle after it.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ucfd_pkg.sv
`default_nettype none

package ucfd_pkg;

    typedef enum logic [3:0] {
        OP_PUSH_NONVOL      = 4'd0,
        OP_ALLOC_LARGE      = 4'd1,
        OP_ALLOC_SMALL      = 4'd2,
        OP_SET_FPREG        = 4'd3,
        OP_SAVE_NONVOL      = 4'd4,
        OP_SAVE_NONVOL_FAR  = 4'd5,
        OP_EPILOG           = 4'd6,
        OP_SPARE            = 4'd7,
        OP_SAVE_XMM128      = 4'd8,
        OP_SAVE_XMM128_FAR  = 4'd9,
        OP_PUSH_MACHFRAME   = 4'd10
    } opcode_t;

    localparam logic [3:0]  FP_REG_NUM       = 4'd5;
    localparam logic [3:0]  INFO_ALLOC_SCALED = 4'd0;
    localparam logic [3:0]  INFO_ALLOC_RAW    = 4'd1;
    localparam logic [31:0] PUSH_SIZE        = 32'h0000_0008;
    localparam logic [31:0] MACHFRAME_SIZE   = 32'h0000_0028;
    localparam logic [31:0] MACHFRAME_ERR_SIZE = 32'h0000_0030;

    typedef struct packed {
        logic [31:0] frame_size;
        logic [31:0] fp_offset;
        logic        machframe;
        logic [1:0]  pending;
        logic [31:0] operand_acc;
        logic [7:0]  held_offset;
        logic [7:0]  held_op_info;
    } ucfd_state_t;

    typedef struct packed {
        logic [7:0]  prolog_offset;
        logic [7:0]  op_and_info;
        logic [31:0] frame_size_after;
        logic [31:0] fp_save_offset;
        logic        machine_frame;
        logic        truncated;
        logic        end_of_codes;
    } ucfd_rec_t;

endpackage

`default_nettype wire

FILE: sv/ucfd_decode.sv
`default_nettype none

module ucfd_decode
    import ucfd_pkg::*;
(
    input  ucfd_state_t cur,
    input  logic        first,
    input  logic [7:0]  slot_low,
    input  logic [7:0]  slot_high,
    input  logic        last,
    output ucfd_state_t nxt,
    output logic        emit,
    output ucfd_rec_t   rec
);

    function automatic logic [1:0] operand_slots(input logic [7:0] op_info);
        logic [3:0] info;
        logic [1:0] n;
        begin
            info = op_info[7:4];
            unique case (opcode_t'(op_info[3:0]))
                OP_ALLOC_LARGE:
                begin
                    if (info == INFO_ALLOC_SCALED)
                        n = 2'd1;
                    else if (info == INFO_ALLOC_RAW)
                        n = 2'd2;
                    else
                        n = 2'd0;
                end
                OP_SAVE_NONVOL, OP_SAVE_XMM128:         n = 2'd1;
                OP_SAVE_NONVOL_FAR, OP_SAVE_XMM128_FAR: n = 2'd2;
                default:                                n = 2'd0;
            endcase
            return n;
        end
    endfunction

    ucfd_state_t st;
    logic [15:0] word;
    logic [1:0]  n_new;
    logic [1:0]  n_total;
    logic [1:0]  pend_dec;
    logic [31:0] acc_next;
    logic [1:0]  pend_next;
    logic [7:0]  held_off_next;
    logic [7:0]  held_op_next;
    logic        do_apply;
    logic [7:0]  apply_op;
    logic [31:0] apply_operand;
    logic [7:0]  rec_off;
    logic [7:0]  rec_op;
    logic        rec_trunc;
    logic        rec_end;

    logic [3:0]  a_info;
    logic [31:0] addend;
    logic [31:0] size_sum;
    logic [31:0] new_size;
    logic [31:0] new_fp;
    logic        new_mf;

    // A new code array starts from a clean state.
    assign st   = first ? '0 : cur;
    assign word = {slot_high, slot_low};

    always_comb
    begin
        n_new         = operand_slots(slot_high);
        n_total       = operand_slots(st.held_op_info);
        pend_dec      = st.pending - 2'd1;
        acc_next      = st.operand_acc;
        pend_next     = st.pending;
        held_off_next = st.held_offset;
        held_op_next  = st.held_op_info;
        do_apply      = 1'b0;
        apply_op      = slot_high;
        apply_operand = '0;
        emit          = 1'b0;
        rec_off       = slot_low;
        rec_op        = slot_high;
        rec_trunc     = 1'b0;
        rec_end       = last;
        if (st.pending == 2'd0)
        begin
            if (n_new == 2'd0)
            begin
                do_apply = 1'b1;
                emit     = 1'b1;
            end
            else
            begin
                held_off_next = slot_low;
                held_op_next  = slot_high;
                acc_next      = '0;
                pend_next     = last ? 2'd0 : n_new;
                emit          = last;
                rec_trunc     = 1'b1;
            end
        end
        else
        begin
            // Second slot of a two-slot operand fills the upper half.
            if (n_total == 2'd2 && st.pending == 2'd1)
                acc_next = {word, st.operand_acc[15:0]};
            else
                acc_next = {16'd0, word};
            apply_op      = st.held_op_info;
            apply_operand = acc_next;
            rec_off       = st.held_offset;
            rec_op        = st.held_op_info;
            if (pend_dec == 2'd0)
            begin
                pend_next = 2'd0;
                do_apply  = 1'b1;
                emit      = 1'b1;
            end
            else
            begin
                pend_next = last ? 2'd0 : pend_dec;
                emit      = last;
                rec_trunc = 1'b1;
            end
        end
    end

    // Frame size, frame pointer and machine frame effect of a completed code.
    assign a_info   = apply_op[7:4];
    assign size_sum = st.frame_size + addend;

    always_comb
    begin
        addend = '0;
        new_fp = st.fp_offset;
        new_mf = st.machframe;
        unique case (opcode_t'(apply_op[3:0]))
            OP_PUSH_NONVOL:
            begin
                addend = PUSH_SIZE;
                if (a_info == FP_REG_NUM)
                    new_fp = st.frame_size;
            end
            OP_ALLOC_LARGE:
            begin
                if (a_info == INFO_ALLOC_SCALED)
                    addend = {13'd0, apply_operand[15:0], 3'd0};
                else if (a_info == INFO_ALLOC_RAW)
                    addend = apply_operand;
            end
            OP_ALLOC_SMALL:
                addend = {25'd0, a_info, 3'd0} + PUSH_SIZE;
            OP_SAVE_NONVOL:
            begin
                if (a_info == FP_REG_NUM)
                    new_fp = {13'd0, apply_operand[15:0], 3'd0};
            end
            OP_SAVE_NONVOL_FAR:
            begin
                if (a_info == FP_REG_NUM)
                    new_fp = apply_operand;
            end
            OP_PUSH_MACHFRAME:
            begin
                addend = (a_info != 4'd0) ? MACHFRAME_ERR_SIZE : MACHFRAME_SIZE;
                new_mf = 1'b1;
            end
            default:
            begin
                addend = '0;
            end
        endcase
    end

    assign new_size = size_sum;

    assign nxt.frame_size   = do_apply ? new_size : st.frame_size;
    assign nxt.fp_offset    = do_apply ? new_fp : st.fp_offset;
    assign nxt.machframe    = do_apply ? new_mf : st.machframe;
    assign nxt.pending      = pend_next;
    assign nxt.operand_acc  = acc_next;
    assign nxt.held_offset  = held_off_next;
    assign nxt.held_op_info = held_op_next;

    assign rec.prolog_offset    = rec_off;
    assign rec.op_and_info      = rec_op;
    assign rec.frame_size_after = nxt.frame_size;
    assign rec.fp_save_offset   = nxt.fp_offset;
    assign rec.machine_frame    = nxt.machframe;
    assign rec.truncated        = rec_trunc;
    assign rec.end_of_codes     = rec_end;

endmodule

`default_nettype wire

FILE: sv/unwind_code_frame_decoder_top.sv
`default_nettype none

// Decodes an x64 prolog unwind code array, one two-byte slot per transaction, and emits one
// record per completed code with the running frame size, the frame pointer save offset and
// the machine frame flag; a code whose operand slots are cut short by last gives a record
// marked truncated. The block takes a slot every cycle unless slot_stall is high: a slot
// lands in an input register, the decode and 32-bit frame size add run on it against the
// per-function state, and the record is held in an output register. Operand slots that do
// not complete a code give no record. A stalled record holds the decode step, and the slot
// input stalls only while both registers are full.
module unwind_code_frame_decoder_top
    import ucfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        slot_valid,
    output logic             slot_stall,
    input  wire logic        first,
    input  wire logic [7:0]  slot_low,
    input  wire logic [7:0]  slot_high,
    input  wire logic        last,
    output logic             rec_valid,
    input  wire logic        rec_stall,
    output logic [7:0]       prolog_offset,
    output logic [7:0]       op_and_info,
    output logic [31:0]      frame_size_after,
    output logic [31:0]      frame_ptr_save_offset,
    output logic             machine_frame,
    output logic             truncated,
    output logic             end_of_codes
);

    logic        in_valid_reg;
    logic        first_reg;
    logic [7:0]  low_reg;
    logic [7:0]  high_reg;
    logic        last_reg;

    ucfd_state_t st_reg;
    ucfd_state_t st_next;
    logic        emit;
    ucfd_rec_t   rec_next;
    ucfd_rec_t   rec_reg;
    logic        rec_valid_reg;

    logic        out_free;
    logic        advance;
    logic        slot_take;

    assign out_free   = !rec_valid_reg || !rec_stall;
    assign advance    = in_valid_reg && out_free;
    assign slot_stall = in_valid_reg && !out_free;
    assign slot_take  = slot_valid && !slot_stall;

    ucfd_decode u_decode (
        .cur       (st_reg),
        .first     (first_reg),
        .slot_low  (low_reg),
        .slot_high (high_reg),
        .last      (last_reg),
        .nxt       (st_next),
        .emit      (emit),
        .rec       (rec_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rec_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (slot_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                st_reg        <= st_next;
                rec_valid_reg <= emit;
            end
            else if (!rec_stall)
            begin
                rec_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_take)
        begin
            first_reg <= first;
            low_reg   <= slot_low;
            high_reg  <= slot_high;
            last_reg  <= last;
        end
        if (advance && emit)
            rec_reg <= rec_next;
    end

    assign rec_valid             = rec_valid_reg;
    assign prolog_offset         = rec_reg.prolog_offset;
    assign op_and_info           = rec_reg.op_and_info;
    assign frame_size_after      = rec_reg.frame_size_after;
    assign frame_ptr_save_offset = rec_reg.fp_save_offset;
    assign machine_frame         = rec_reg.machine_frame;
    assign truncated             = rec_reg.truncated;
    assign end_of_codes          = rec_reg.end_of_codes;

endmodule

`default_nettype wire

FILE: sv/ucfd_checker.sv
`default_nettype none

`include "assert_macros.svh"

module ucfd_checker
    import ucfd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        slot_stall,
    input wire logic        rec_valid,
    input wire logic        rec_stall,
    input wire logic [7:0]  prolog_offset,
    input wire logic [7:0]  op_and_info,
    input wire logic [31:0] frame_size_after,
    input wire logic        machine_frame,
    input wire logic        truncated,
    input wire logic        end_of_codes
);

    logic rec_held;
    logic trunc_rec;
    logic trunc_op_ok;
    logic mf_rec;

    assign rec_held  = rec_valid && rec_stall;
    assign trunc_rec = rec_valid && truncated;
    // Only codes that take operand slots can be cut short.
    assign trunc_op_ok = op_and_info[3:0] == OP_SAVE_NONVOL
        || op_and_info[3:0] == OP_SAVE_NONVOL_FAR
        || op_and_info[3:0] == OP_SAVE_XMM128
        || op_and_info[3:0] == OP_SAVE_XMM128_FAR
        || op_and_info == {INFO_ALLOC_SCALED, OP_ALLOC_LARGE}
        || op_and_info == {INFO_ALLOC_RAW, OP_ALLOC_LARGE};
    assign mf_rec = rec_valid && !truncated && op_and_info[3:0] == OP_PUSH_MACHFRAME;

    `ASSERT_NEXT(a_rec_hold, clk, rst_n, rec_held,
        rec_valid && $stable(op_and_info) && $stable(frame_size_after)
        && $stable(prolog_offset), "stalled record changed")
    `ASSERT_IMPLY(a_trunc_end, clk, rst_n, trunc_rec, end_of_codes, "truncated record without end of codes")
    `ASSERT_IMPLY(a_trunc_op, clk, rst_n, trunc_rec, trunc_op_ok, "truncated record on code without operands")
    `ASSERT_IMPLY(a_machframe, clk, rst_n, mf_rec, machine_frame, "machine frame code without flag")
    `ASSERT_IMPLY(a_stall_src, clk, rst_n, slot_stall, rec_valid && rec_stall, "slot stall without stalled record")

endmodule

bind unwind_code_frame_decoder_top ucfd_checker u_ucfd_checker (.*);

`default_nettype wire
